// ===== rtl/core/phc_pkg.sv =====
// ----------------------------------------------------------------------------
// phc_pkg
// Shared constants, operation codes and hash unit handshake types for the
// position hash cache.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int WAYS_DEF        = 4;
  localparam int BUCKETS_DEF     = 4096;
  localparam int ACTION_BITS_DEF = 32;

  localparam logic [63:0] MIX_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_B = 64'h94D0_49BB_1331_11EB;

  localparam logic [1:0] FN_PROBE = 2'd0;
  localparam logic [1:0] FN_STORE = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION = 1'd1;

  localparam logic [30:0] MATE_LIMIT_RST = 31'd30000;
  localparam logic [15:0] GENERATION_RST = 16'd1;

  typedef struct packed {
    logic        start;
    logic [63:0] seed;
  } phc_mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } phc_mix_rsp_t;

endpackage

// ===== rtl/core/phc_ifs.sv =====
// ----------------------------------------------------------------------------
// phc_ifs
// Item channels of the position hash cache: operation requests and results.
// ----------------------------------------------------------------------------
interface phc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [63:0]        key_hash_lo;
  logic [63:0]        key_hash_hi;
  logic [63:0]        key_rep_lo;
  logic [63:0]        key_rep_hi;
  logic [15:0]        position_ply;
  logic [15:0]        history_length;
  logic [9:0]         search_ply;
  logic signed [15:0] search_depth;
  logic signed [31:0] score_in;
  logic [31:0]        action_in;
  logic               action_valid_in;

  modport source (output valid, func, key_hash_lo, key_hash_hi, key_rep_lo, key_rep_hi,
                  position_ply, history_length, search_ply, search_depth, score_in,
                  action_in, action_valid_in, input ready);
  modport sink (input valid, func, key_hash_lo, key_hash_hi, key_rep_lo, key_rep_hi,
                position_ply, history_length, search_ply, search_depth, score_in,
                action_in, action_valid_in, output ready);
endinterface

interface phc_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] found_score;
  logic [31:0]        found_action;
  logic               found_action_valid;
  logic signed [15:0] found_depth;
  logic [2:0]         collision_count;
  logic               slot_was_occupied;
  logic [14:0]        entries_in_use;

  modport source (output valid, hit, found_score, found_action, found_action_valid,
                  found_depth, collision_count, slot_was_occupied, entries_in_use,
                  input ready);
  modport sink (input valid, hit, found_score, found_action, found_action_valid,
                found_depth, collision_count, slot_was_occupied, entries_in_use,
                output ready);
endinterface

// ===== rtl/core/phc_mixer.sv =====
// ----------------------------------------------------------------------------
// phc_mixer
// Multi-cycle 64-bit finalizer: each 64x64 product is built from three
// 32x32 partial products in one state and summed in the next.
// ----------------------------------------------------------------------------
module phc_mixer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  phc_pkg::phc_mix_req_t req,
  output phc_pkg::phc_mix_rsp_t rsp
);

  typedef enum logic [2:0] {MX_IDLE, MX_P1, MX_C1, MX_P2, MX_C2} mx_state_t;

  mx_state_t   state_r;
  logic [63:0] x_r;
  logic [63:0] p_ll_r;
  logic [31:0] p_lh_r;
  logic [31:0] p_hl_r;
  logic        done_r;
  logic [63:0] k;
  logic [63:0] y;

  assign k = (state_r == MX_P1) ? phc_pkg::MIX_A : phc_pkg::MIX_B;
  assign y = p_ll_r + {p_lh_r + p_hl_r, 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MX_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == MX_C2);
      unique case (state_r)
        MX_IDLE: begin
          if (req.start) begin
            x_r     <= req.seed ^ (req.seed >> 30);
            state_r <= MX_P1;
          end
        end
        MX_P1, MX_P2: begin
          p_ll_r  <= 64'(x_r[31:0] * k[31:0]);
          p_lh_r  <= 32'(x_r[31:0] * k[63:32]);
          p_hl_r  <= 32'(x_r[63:32] * k[31:0]);
          state_r <= (state_r == MX_P1) ? MX_C1 : MX_C2;
        end
        MX_C1: begin
          x_r     <= y ^ (y >> 27);
          state_r <= MX_P2;
        end
        MX_C2: begin
          x_r     <= y ^ (y >> 31);
          state_r <= MX_IDLE;
        end
        default: state_r <= MX_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.hash = x_r;

endmodule

// ===== rtl/core/position_hash_cache_core.sv =====
// ----------------------------------------------------------------------------
// position_hash_cache_core
// Set-associative position cache with probe, store and clear operations.
// ----------------------------------------------------------------------------
// One item is handled at a time. For a probe or a store the folded key seeds
// the hash unit at the accepting edge, the multi-cycle finalizer then runs
// its two multiplies, each split into partial products, the bucket is read
// from the synchronous row memory, and the block then compares, chooses a way
// and, on a store, writes the row back. The block is ready again as the
// result appears, so it takes no new item before the last one has its result.
// An unused operation code skips the hash unit and the row memory. A clear
// sweeps the row memory one bucket a cycle; the same sweep runs after reset,
// and no item is accepted until it is over (configuration writes are taken
// throughout). Each bucket is one memory row holding all of its ways with
// their valid flags, so the block needs one row read per probe or store and
// one row write per store.
// A finished result sits in an output register and the next item is accepted
// while it waits to be taken; that item then stalls in its last cycle until
// the output register is free.
module position_hash_cache_core #(
  parameter int WAYS        = phc_pkg::WAYS_DEF,
  parameter int BUCKETS     = phc_pkg::BUCKETS_DEF,
  parameter int ACTION_BITS = phc_pkg::ACTION_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  phc_in_if.sink                          in_ch,
  phc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [phc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [phc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS = BUCKETS * WAYS;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);
  localparam logic signed [33:0] SMAX = 34'sh07FFFFFFF;
  localparam logic signed [33:0] SMIN = -34'sh080000000;

  typedef struct packed {
    logic                   valid;
    logic [63:0]            hash_lo;
    logic [63:0]            hash_hi;
    logic [63:0]            rep_lo;
    logic [63:0]            rep_hi;
    logic [31:0]            ph;
    logic signed [31:0]     score;
    logic signed [15:0]     depth;
    logic [ACTION_BITS-1:0] action;
    logic                   act_valid;
    logic [15:0]            gen;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] found_score;
    logic [31:0]        found_action;
    logic               found_action_valid;
    logic signed [15:0] found_depth;
    logic [2:0]         collision_count;
    logic               slot_was_occupied;
    logic [14:0]        entries_in_use;
  } result_t;

  typedef enum logic [1:0] {S_CLR, S_IDLE, S_HASH, S_EXEC} state_t;

  // Mate scores move away from zero by the ply on store and back on probe.
  function automatic logic signed [31:0] mate_adj(input logic signed [31:0] s,
                                                  input logic [30:0] lim,
                                                  input logic [9:0] ply,
                                                  input logic up);
    logic signed [33:0] s34;
    logic signed [33:0] l34;
    logic signed [33:0] p34;
    logic signed [33:0] r;
    s34 = 34'(s);
    l34 = $signed({3'b000, lim});
    p34 = $signed({24'd0, ply});
    r   = s34;
    if (s34 > l34) r = up ? s34 + p34 : s34 - p34;
    else if (s34 < -l34) r = up ? s34 - p34 : s34 + p34;
    if (r > SMAX) r = SMAX;
    else if (r < SMIN) r = SMIN;
    return r[31:0];
  endfunction

  // Configuration and counters.
  logic [30:0]      mate_limit_r;
  logic [15:0]      gen_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // Control.
  state_t           state_r;
  logic [BKT_W-1:0] sweep_r;
  logic             report_r;
  logic             out_valid_r;
  result_t          out_r;
  result_t          res_nxt;

  // Captured item.
  logic [1:0]         func_r;
  logic [63:0]        hash_lo_r;
  logic [63:0]        hash_hi_r;
  logic [63:0]        rep_lo_r;
  logic [63:0]        rep_hi_r;
  logic [31:0]        ph_r;
  logic [9:0]         ply_r;
  logic signed [15:0] depth_r;
  logic signed [31:0] score_r;
  logic [31:0]        act_r;
  logic               actv_r;
  logic [BKT_W-1:0]   bkt_r;

  // Row memory.
  row_t             mem [BUCKETS];
  row_t             rdata_r;
  row_t             wrow;
  logic             mem_we;
  logic [BKT_W-1:0] mem_waddr;
  logic             mem_re;
  logic [BKT_W-1:0] mem_raddr;

  phc_pkg::phc_mix_req_t mix_req;
  phc_pkg::phc_mix_rsp_t mix_rsp;

  logic in_acc;
  logic can_out;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign can_out = !out_valid_r || out_ch.ready;

  assign mix_req.start = in_acc && (in_ch.func == phc_pkg::FN_PROBE ||
                                    in_ch.func == phc_pkg::FN_STORE);
  assign mix_req.seed  = in_ch.key_hash_lo ^ in_ch.key_hash_hi ^ in_ch.key_rep_lo ^
                         in_ch.key_rep_hi ^ {47'd0, in_ch.position_ply, 1'b0} ^
                         {46'd0, in_ch.history_length, 2'b00};

  phc_mixer u_mixer (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mix_req),
    .rsp   (mix_rsp)
  );

  assign mem_re    = (state_r == S_HASH) && mix_rsp.done;
  assign mem_raddr = mix_rsp.hash[BKT_W-1:0] & BKT_LAST;

  // Lookup, way choice and the row to write back.
  always_comb begin
    logic             mfound;
    logic [WAY_W-1:0] mw;
    logic [2:0]       coll;
    logic             ffound;
    logic [WAY_W-1:0] fw;
    logic [WAY_W-1:0] ow;
    logic [WAY_W-1:0] tw;
    logic [63:0]      act64;
    logic             mt;
    mfound = 1'b0;
    mw     = '0;
    coll   = '0;
    ffound = 1'b0;
    fw     = '0;
    ow     = '0;
    for (int w = 0; w < WAYS; w++) begin
      mt = rdata_r[w].valid && rdata_r[w].hash_lo == hash_lo_r &&
           rdata_r[w].hash_hi == hash_hi_r && rdata_r[w].rep_lo == rep_lo_r &&
           rdata_r[w].rep_hi == rep_hi_r && rdata_r[w].ph == ph_r;
      if (!mfound && rdata_r[w].valid) begin
        if (mt) begin
          mfound = 1'b1;
          mw     = WAY_W'(w);
        end else if (coll != 3'd7) begin
          coll = coll + 3'd1;
        end
      end
      if (!ffound && !rdata_r[w].valid) begin
        ffound = 1'b1;
        fw     = WAY_W'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      if (rdata_r[w].gen < rdata_r[ow].gen ||
          (rdata_r[w].gen == rdata_r[ow].gen && rdata_r[w].depth < rdata_r[ow].depth))
        ow = WAY_W'(w);
    end
    if (mfound && (depth_r >= rdata_r[mw].depth || gen_r > rdata_r[mw].gen)) tw = mw;
    else if (ffound) tw = fw;
    else tw = ow;

    act64   = 64'(rdata_r[mw].action);
    res_nxt = '0;
    cnt_nxt = cnt_r;
    wrow    = rdata_r;
    if (func_r == phc_pkg::FN_PROBE) begin
      res_nxt.collision_count = coll;
      if (mfound) begin
        res_nxt.hit                = 1'b1;
        res_nxt.found_score        = mate_adj(rdata_r[mw].score, mate_limit_r, ply_r, 1'b0);
        res_nxt.found_action       = act64[31:0];
        res_nxt.found_action_valid = rdata_r[mw].act_valid;
        res_nxt.found_depth        = rdata_r[mw].depth;
      end
    end else if (func_r == phc_pkg::FN_STORE) begin
      res_nxt.hit               = 1'b1;
      res_nxt.slot_was_occupied = rdata_r[tw].valid;
      if (!rdata_r[tw].valid) cnt_nxt = cnt_r + CNT_W'(1);
      wrow[tw].valid     = 1'b1;
      wrow[tw].hash_lo   = hash_lo_r;
      wrow[tw].hash_hi   = hash_hi_r;
      wrow[tw].rep_lo    = rep_lo_r;
      wrow[tw].rep_hi    = rep_hi_r;
      wrow[tw].ph        = ph_r;
      wrow[tw].score     = mate_adj(score_r, mate_limit_r, ply_r, 1'b1);
      wrow[tw].depth     = depth_r;
      wrow[tw].action    = ACTION_BITS'({32'd0, act_r});
      wrow[tw].act_valid = actv_r;
      wrow[tw].gen       = gen_r;
    end
    res_nxt.entries_in_use = (cnt_nxt > CNT_W'(32767)) ? 15'h7FFF : 15'(cnt_nxt);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bkt_r;
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_r;
    end else if (state_r == S_EXEC && can_out && func_r == phc_pkg::FN_STORE) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= (state_r == S_CLR) ? row_t'('0) : wrow;
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // Item capture needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_ch.func;
      hash_lo_r <= in_ch.key_hash_lo;
      hash_hi_r <= in_ch.key_hash_hi;
      rep_lo_r  <= in_ch.key_rep_lo;
      rep_hi_r  <= in_ch.key_rep_hi;
      ph_r      <= {in_ch.history_length, in_ch.position_ply};
      ply_r     <= in_ch.search_ply;
      depth_r   <= in_ch.search_depth;
      score_r   <= in_ch.score_in;
      act_r     <= in_ch.action_in;
      actv_r    <= in_ch.action_valid_in;
    end
    if (mem_re) bkt_r <= mem_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      sweep_r      <= '0;
      report_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
      mate_limit_r <= phc_pkg::MATE_LIMIT_RST;
      gen_r        <= phc_pkg::GENERATION_RST;
    end else begin
      // A result finishing in this cycle refills the output register itself.
      if (out_valid_r && out_ch.ready && state_r != S_EXEC) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          phc_pkg::CFG_MATE_LIMIT: mate_limit_r <= cfg_wdata[30:0];
          phc_pkg::CFG_GENERATION: gen_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_CLR: begin
          // The sweep counter steps past the last bucket, wrapping to zero when BUCKETS is a power of two.
          sweep_r <= sweep_r + BKT_W'(1);
          if (sweep_r == BKT_LAST) begin
            state_r <= report_r ? S_EXEC : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.func == phc_pkg::FN_CLEAR) begin
              gen_r    <= phc_pkg::GENERATION_RST;
              cnt_r    <= '0;
              sweep_r  <= '0;
              report_r <= 1'b1;
              state_r  <= S_CLR;
            end else if (mix_req.start) begin
              state_r <= S_HASH;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_HASH: begin
          if (mix_rsp.done) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (can_out) begin
            out_r       <= res_nxt;
            out_valid_r <= 1'b1;
            cnt_r       <= cnt_nxt;
            report_r    <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.hit                = out_r.hit;
  assign out_ch.found_score        = out_r.found_score;
  assign out_ch.found_action       = out_r.found_action;
  assign out_ch.found_action_valid = out_r.found_action_valid;
  assign out_ch.found_depth        = out_r.found_depth;
  assign out_ch.collision_count    = out_r.collision_count;
  assign out_ch.slot_was_occupied  = out_r.slot_was_occupied;
  assign out_ch.entries_in_use     = out_r.entries_in_use;

  // The hash unit only finishes while an operation waits for its bucket.
  a_mix_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
    mix_rsp.done |-> state_r == S_HASH)
    else $error("hash unit finished outside the hash wait");

  // An accepted clear empties the entry count at once.
  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.func == phc_pkg::FN_CLEAR |=> cnt_r == '0)
    else $error("entry count not cleared by clear operation");

  // The entry count never exceeds the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("entry count beyond table size");

  // A row read never coincides with a row write.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("row read and write in the same cycle");

endmodule
